// File: design/hset_pkg.sv
// hset_pkg: shared types and codes for the hashed integer set
// holds the operation codes and the request / response transaction structs
// no dependencies
`default_nettype none

package hset_pkg;

	localparam int KEY_W = 32;

	// operation codes; the unused code behaves as a test
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_TEST   = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	// status codes
	localparam logic ST_DONE = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef struct packed {
		logic [1:0]              operation;
		logic signed [KEY_W-1:0] key;
	} request_t;

	typedef struct packed {
		logic was_present;
		logic status;
	} response_t;

endpackage

`default_nettype wire

// File: design/hashed_integer_set.sv
// Hashed integer set of signed 32-bit keys in BUCKETS buckets of WAYS ways.
// A transaction is accepted at a clock edge with start high and busy low; its
// response appears on the response port for exactly one cycle with done high
// and cannot be held off. After reset the block stays busy while the valid rows
// are swept clear. After acceptance a transaction passes through the bucket
// remainder unit (a shared multiplier used twice, a subtract and one correction),
// a state that reads the bucket's row of valid bits and forms its base address,
// a row latch, a key read and a compare for each way through the single key
// memory read port and the shared key compare, and an update state that raises done.
// busy drops together with done, so a new transaction can be accepted only once
// the previous one has completed.
// hashed_integer_set: top level, sequencer with shared compare over the ways
// depends on hset_pkg, hset_mod, hset_store
`default_nettype none

module hashed_integer_set import hset_pkg::*; #(
	parameter int BUCKETS = 1024,
	parameter int WAYS    = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire request_t  request,
	output logic           done,
	output response_t      response
);

	localparam int BW = $clog2(BUCKETS);
	localparam int AW = $clog2(BUCKETS * WAYS);
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [AW-1:0] WAYS_A   = AW'(WAYS);
	localparam logic [WW-1:0] LAST_WAY = WW'(WAYS - 1);

	// sequencer states
	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_BASE = 3'd3;
	localparam logic [2:0] S_ROW  = 3'd4;
	localparam logic [2:0] S_RDK  = 3'd5;
	localparam logic [2:0] S_CMP  = 3'd6;
	localparam logic [2:0] S_UPD  = 3'd7;

	logic [2:0]       state_q;
	logic [1:0]       op_q;
	logic [KEY_W-1:0] key_q;
	logic [BW-1:0]    bucket_q;
	logic [AW-1:0]    base_q;
	logic [WAYS-1:0]  row_q;
	logic [WW-1:0]    way_q;
	logic             hit_q;
	logic [WW-1:0]    hit_way_q;
	logic             done_q;
	response_t        resp_q;

	logic             accept;
	logic             mod_done;
	logic [BW-1:0]    mod_bucket;
	logic             store_ready;
	logic [WAYS-1:0]  row_rdata;
	logic [KEY_W-1:0] key_rdata;
	logic             free_any;
	logic [WW-1:0]    free_way;
	logic             do_ins;
	logic             do_del;
	logic             row_we;
	logic [WAYS-1:0]  row_wdata;
	logic             key_match;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	hset_mod #(
		.BUCKETS(BUCKETS)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (request.key),
		.done   (mod_done),
		.bucket (mod_bucket)
	);

	// lowest free way of the latched row
	always_comb begin
		free_any = 1'b0;
		free_way = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (!row_q[i]) begin
				free_any = 1'b1;
				free_way = WW'(i);
			end
		end
	end

	// update decisions
	always_comb begin
		do_ins    = (state_q == S_UPD) && (op_q == OP_INSERT) && !hit_q && free_any;
		do_del    = (state_q == S_UPD) && (op_q == OP_DELETE) && hit_q;
		row_we    = do_ins || do_del;
		row_wdata = do_ins ? (row_q | (WAYS'(1) << free_way))
		                   : (row_q & ~(WAYS'(1) << hit_way_q));
	end

	// shared key compare
	assign key_match = row_q[way_q] && (key_rdata == key_q);

	hset_store #(
		.BUCKETS(BUCKETS),
		.WAYS   (WAYS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ready     (store_ready),
		.row_re    (state_q == S_BASE),
		.row_raddr (bucket_q),
		.row_rdata (row_rdata),
		.row_we    (row_we),
		.row_waddr (bucket_q),
		.row_wdata (row_wdata),
		.key_re    (state_q == S_RDK),
		.key_raddr (base_q + AW'(way_q)),
		.key_rdata (key_rdata),
		.key_we    (do_ins),
		.key_waddr (base_q + AW'(free_way)),
		.key_wdata (key_q)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					if (store_ready)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (mod_done)
						state_q <= S_BASE;
				end
				S_BASE: state_q <= S_ROW;
				S_ROW:  state_q <= S_RDK;
				S_RDK:  state_q <= S_CMP;
				S_CMP: begin
					if (way_q == LAST_WAY)
						state_q <= S_UPD;
					else
						state_q <= S_RDK;
				end
				S_UPD: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// transaction datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= request.operation;
			key_q <= request.key;
		end
		if (state_q == S_DIV && mod_done)
			bucket_q <= mod_bucket;
		if (state_q == S_BASE)
			base_q <= AW'(bucket_q) * WAYS_A;
		if (state_q == S_ROW) begin
			row_q     <= row_rdata;
			way_q     <= '0;
			hit_q     <= 1'b0;
			hit_way_q <= '0;
		end
		if (state_q == S_CMP) begin
			if (key_match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_way_q <= way_q;
			end
			if (way_q != LAST_WAY)
				way_q <= way_q + WW'(1);
		end
		if (state_q == S_UPD) begin
			resp_q.was_present <= hit_q;
			resp_q.status      <= ((op_q == OP_INSERT) && !hit_q && !free_any)
			                      ? ST_FULL : ST_DONE;
		end
	end

	assign done     = done_q;
	assign response = resp_q;

endmodule

`default_nettype wire

// File: design/hset_mod.sv
// hset_mod: bucket index unit, |key| mod BUCKETS by reciprocal multiplication
// one shared 32 by 32 multiplier used twice, then a subtract and one correction step
// depends on hset_pkg
`default_nettype none

module hset_mod import hset_pkg::*; #(
	parameter int BUCKETS = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [KEY_W-1:0]        key,
	output logic                         done,
	output logic [$clog2(BUCKETS)-1:0]   bucket
);

	localparam int BW = $clog2(BUCKETS);
	localparam int RW = BW + 1;
	localparam int PW = 2 * KEY_W;
	// floor(2^32 / BUCKETS); the quotient estimate is low by at most one
	localparam logic [KEY_W-1:0] RECIP_C = KEY_W'((64'd1 << KEY_W) / 64'(BUCKETS));
	localparam logic [KEY_W-1:0] DIV_C   = KEY_W'(BUCKETS);
	localparam logic [RW-1:0]    DIV_R   = RW'(BUCKETS);

	// iteration phases
	localparam logic [1:0] PH_QUOT = 2'd0;
	localparam logic [1:0] PH_BACK = 2'd1;
	localparam logic [1:0] PH_SUB  = 2'd2;
	localparam logic [1:0] PH_FIX  = 2'd3;

	logic [KEY_W-1:0] mag_q;
	logic [PW-1:0]    prod_q;
	logic [RW-1:0]    rem_q;
	logic [BW-1:0]    bucket_q;
	logic [1:0]       ph_q;
	logic             run_q;
	logic             done_q;
	logic [KEY_W-1:0] mag;
	logic [KEY_W-1:0] mul_a;
	logic [KEY_W-1:0] mul_b;
	logic [PW-1:0]    mul_p;
	logic [RW-1:0]    diff;
	logic [BW-1:0]    rem_fix;

	// magnitude; the most negative key wraps to 2^31 as unsigned
	assign mag = key[KEY_W-1] ? (KEY_W'(0) - key) : key;

	// shared multiplier: reciprocal product first, then quotient times bucket count
	always_comb begin
		mul_a   = (ph_q == PH_QUOT) ? mag_q : prod_q[PW-1:KEY_W];
		mul_b   = (ph_q == PH_QUOT) ? RECIP_C : DIV_C;
		mul_p   = PW'(mul_a) * PW'(mul_b);
		// remainder before correction is below twice the bucket count
		diff    = mag_q[RW-1:0] - prod_q[RW-1:0];
		rem_fix = (rem_q >= DIV_R) ? BW'(rem_q - DIV_R) : rem_q[BW-1:0];
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= PH_QUOT;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				ph_q  <= PH_QUOT;
			end else if (run_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == PH_FIX) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
		end else if (run_q) begin
			case (ph_q)
				PH_QUOT: prod_q   <= mul_p;
				PH_BACK: prod_q   <= mul_p;
				PH_SUB:  rem_q    <= diff;
				PH_FIX:  bucket_q <= rem_fix;
				default: ;
			endcase
		end
	end

	assign done   = done_q;
	assign bucket = bucket_q;

endmodule

`default_nettype wire

// File: design/hset_store.sv
// hset_store: key memory and per-bucket valid rows, with the clearing pass
// valid rows are swept to zero bucket by bucket after reset
// depends on hset_pkg
`default_nettype none

module hset_store import hset_pkg::*; #(
	parameter int BUCKETS = 1024,
	parameter int WAYS    = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	output logic                                     ready,
	input  wire logic                                row_re,
	input  wire logic [$clog2(BUCKETS)-1:0]          row_raddr,
	output logic [WAYS-1:0]                          row_rdata,
	input  wire logic                                row_we,
	input  wire logic [$clog2(BUCKETS)-1:0]          row_waddr,
	input  wire logic [WAYS-1:0]                     row_wdata,
	input  wire logic                                key_re,
	input  wire logic [$clog2(BUCKETS*WAYS)-1:0]     key_raddr,
	output logic [KEY_W-1:0]                         key_rdata,
	input  wire logic                                key_we,
	input  wire logic [$clog2(BUCKETS*WAYS)-1:0]     key_waddr,
	input  wire logic [KEY_W-1:0]                    key_wdata
);

	localparam int BW = $clog2(BUCKETS);
	localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);

	logic [WAYS-1:0]  row_mem [BUCKETS];
	logic [KEY_W-1:0] key_mem [BUCKETS * WAYS];
	logic [BW-1:0]    clr_q;
	logic             clearing_q;
	logic             rw_en;
	logic [BW-1:0]    rw_addr;
	logic [WAYS-1:0]  rw_data;

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + BW'(1);
			if (clr_q == LAST_ROW)
				clearing_q <= 1'b0;
		end
	end

	// valid row write port, owned by the sweep while clearing
	always_comb begin
		rw_en   = clearing_q ? 1'b1 : row_we;
		rw_addr = clearing_q ? clr_q : row_waddr;
		rw_data = clearing_q ? '0 : row_wdata;
	end

	// valid row memory
	always_ff @(posedge clk) begin
		if (rw_en)
			row_mem[rw_addr] <= rw_data;
		if (row_re)
			row_rdata <= row_mem[row_raddr];
	end

	// key memory
	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[key_waddr] <= key_wdata;
		if (key_re)
			key_rdata <= key_mem[key_raddr];
	end

	assign ready = !clearing_q;

endmodule

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking testbench for the hashed integer set
// directed table then pooled random transactions, checked against a local set predictor
// depends on hset_pkg and hashed_integer_set
`timescale 1ns / 1ps

module tb;
	import hset_pkg::*;

	localparam int BUCKETS = 1024;
	localparam int WAYS = 4;
	localparam int RANDOM_ITEMS = 950;
	localparam int POOL_SIZE = 16;
	localparam int TAIL_CYCLES = 60;
	localparam int CYCLE_LIMIT = 600000;

	// code the block treats as a test
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		request_t  req;
		bit        typed;
		response_t resp;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	request_t  request;
	logic      done;
	response_t response;

	// predictor copy of the set
	logic [31:0] held_key [BUCKETS][WAYS];
	bit          way_used [BUCKETS][WAYS];

	response_t   pending_replies[$];
	dir_row_t    directed_rows[$];
	logic [31:0] key_pool [POOL_SIZE];
	int          burst_left;
	int          mismatches;
	int          reply_count;
	int          cycles;
	response_t   due;

	hashed_integer_set #(
		.BUCKETS(BUCKETS),
		.WAYS(WAYS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.response(response)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at response %0d: %s", reply_count, what);
		mismatches++;
	endtask

	// set behavior: bucket from key magnitude, lowest free way on insert
	function automatic response_t set_apply(input request_t req);
		logic [31:0] bits;
		logic [31:0] mag;
		int unsigned row;
		int hit;
		int free_way;
		response_t r;
		bits = req.key;
		mag = bits[31] ? (32'd0 - bits) : bits;
		row = mag % 32'(BUCKETS);
		hit = -1;
		free_way = -1;
		for (int w = 0; w < WAYS; w++) begin
			if (way_used[row][w]) begin
				if (hit < 0 && held_key[row][w] == bits)
					hit = w;
			end else if (free_way < 0) begin
				free_way = w;
			end
		end
		r.was_present = (hit >= 0);
		r.status = ST_DONE;
		case (req.operation)
			OP_INSERT: begin
				if (hit < 0) begin
					if (free_way >= 0) begin
						held_key[row][free_way] = bits;
						way_used[row][free_way] = 1'b1;
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			OP_DELETE: begin
				if (hit >= 0)
					way_used[row][hit] = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// one transaction: hold start until accepted, then maybe idle
	task automatic issue(input request_t req, input bit typed, input response_t typed_resp);
		response_t predicted;
		request <= req;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = set_apply(req);
		pending_replies.push_back(typed ? typed_resp : predicted);
		burst_left--;
		if (burst_left <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 70))
				@(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
	endtask

	task automatic add_row(input logic [1:0] op, input logic [31:0] key, input bit typed,
			input logic present, input logic status);
		dir_row_t row;
		row.req.operation = op;
		row.req.key = key;
		row.typed = typed;
		row.resp.was_present = present;
		row.resp.status = status;
		directed_rows.push_back(row);
	endtask

	// few hot buckets with more keys than ways, so hits, fulls and deletes are common
	task automatic refill_pool();
		logic [31:0] hot [3];
		logic [31:0] mag;
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(0, 5))
				0: hot[i] = 0;
				1: hot[i] = BUCKETS - 1;
				default: hot[i] = $urandom_range(0, BUCKETS - 1);
			endcase
		end
		for (int i = 0; i < POOL_SIZE; i++) begin
			mag = hot[i % 3] + 32'(BUCKETS) * $urandom_range(0, 2097151);
			key_pool[i] = $urandom_range(0, 1) ? (32'd0 - mag) : mag;
		end
	endtask

	// response check against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("response with nothing pending");
			end else begin
				due = pending_replies.pop_front();
				if (response.was_present !== due.was_present)
					report_mismatch($sformatf("was_present %b, predicted %b",
						response.was_present, due.was_present));
				if (response.status !== due.status)
					report_mismatch($sformatf("status %b, predicted %b",
						response.status, due.status));
			end
			reply_count++;
		end
	end

	// stimulus
	initial begin
		request_t req;
		response_t none;
		int pick;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		mismatches = 0;
		reply_count = 0;
		none = '0;
		burst_left = $urandom_range(1, 12);
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;

		// empty set, duplicates, absent delete, extreme keys
		add_row(OP_TEST,   32'd0,          1'b1, 1'b0, ST_DONE);
		add_row(OP_INSERT, 32'd0,          1'b1, 1'b0, ST_DONE);
		add_row(OP_INSERT, 32'd0,          1'b1, 1'b1, ST_DONE);
		add_row(OP_TEST,   32'd0,          1'b1, 1'b1, ST_DONE);
		add_row(OP_DELETE, 32'd0,          1'b1, 1'b1, ST_DONE);
		add_row(OP_DELETE, 32'd0,          1'b1, 1'b0, ST_DONE);
		add_row(OP_TEST,   32'h8000_0000,  1'b1, 1'b0, ST_DONE);
		add_row(OP_INSERT, 32'h8000_0000,  1'b1, 1'b0, ST_DONE);
		add_row(OP_INSERT, 32'h7fff_ffff,  1'b1, 1'b0, ST_DONE);
		add_row(OP_TEST,   32'h8000_0000,  1'b1, 1'b1, ST_DONE);
		add_row(OP_TEST,   32'h7fff_ffff,  1'b1, 1'b1, ST_DONE);
		// fill one bucket, then overflow it
		add_row(OP_INSERT, 32'd5,          1'b1, 1'b0, ST_DONE);
		add_row(OP_INSERT, -32'sd5,        1'b1, 1'b0, ST_DONE);
		add_row(OP_INSERT, 32'd1029,       1'b1, 1'b0, ST_DONE);
		add_row(OP_INSERT, -32'sd1029,     1'b1, 1'b0, ST_DONE);
		add_row(OP_INSERT, 32'd2053,       1'b1, 1'b0, ST_FULL);
		add_row(OP_TEST,   32'd2053,       1'b1, 1'b0, ST_DONE);
		add_row(OP_UNUSED, 32'd5,          1'b1, 1'b1, ST_DONE);
		add_row(OP_DELETE, -32'sd5,        1'b1, 1'b1, ST_DONE);
		// freed way gets reused
		add_row(OP_INSERT, 32'd2053,       1'b0, 1'b0, ST_DONE);
		add_row(OP_TEST,   32'd2053,       1'b0, 1'b0, ST_DONE);
		add_row(OP_TEST,   -32'sd5,        1'b0, 1'b0, ST_DONE);
		add_row(OP_INSERT, 32'hffff_ffff,  1'b0, 1'b0, ST_DONE);
		add_row(OP_TEST,   32'd1,          1'b0, 1'b0, ST_DONE);

		foreach (directed_rows[i])
			issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].resp);

		// random: mostly hot-bucket keys, some full-range noise
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 200 == 0)
				refill_pool();
			if ($urandom_range(0, 4) == 0) begin
				req.operation = 2'($urandom_range(0, 3));
				req.key = $urandom;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 45)
					req.operation = OP_INSERT;
				else if (pick < 65)
					req.operation = OP_TEST;
				else if (pick < 95)
					req.operation = OP_DELETE;
				else
					req.operation = OP_UNUSED;
				req.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			end
			issue(req, 1'b0, none);
		end

		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (pending_replies.size() != 0)
			report_mismatch("predicted responses never arrived");
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: hashed_integer_set.f
design/hset_pkg.sv
design/hset_mod.sv
design/hset_store.sv
design/hashed_integer_set.sv
tb/tb.sv
